[rtl/nce_pkg.sv]
// Package for the nibble CPU register and accumulator execute block.
// Holds the opcode codes, field widths and the structs shared by the modules.
// Has no dependencies of its own.
`default_nettype none

package nce_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int TICK_OUT_W     = 32;
	localparam int NIB_W          = 4;
	localparam int BYTE_W         = 8;
	localparam int ROWS           = 8;
	localparam int ROW_W          = $clog2(ROWS);
	localparam int IN_DATA_W      = 16;
	localparam int OUT_DATA_W     = 72;

	localparam logic [NIB_W-1:0] NIB_ALL = 4'b1111;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_LDM = 4'd1;
	localparam logic [3:0] OP_LD  = 4'd2;
	localparam logic [3:0] OP_XCH = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_SUB = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_BBL = 4'd7;
	localparam logic [3:0] OP_JIN = 4'd8;
	localparam logic [3:0] OP_SRC = 4'd9;
	localparam logic [3:0] OP_FIN = 4'd10;
	localparam logic [3:0] OP_CLB = 4'd11;
	localparam logic [3:0] OP_CLC = 4'd12;
	localparam logic [3:0] OP_CMC = 4'd13;
	localparam logic [3:0] OP_STC = 4'd14;
	localparam logic [3:0] OP_CMA = 4'd15;

	// The opcode sits in the lowest bits, as on the input stream.
	typedef struct packed {
		logic [BYTE_W-1:0] rom_byte;
		logic [NIB_W-1:0]  operand_nibble;
		logic [3:0]        opcode;
	} instr_t;

	typedef struct packed {
		logic              en_hi;
		logic              en_lo;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic [NIB_W-1:0]      acc_value;
		logic                  carry_value;
		logic [BYTE_W-1:0]     pair_value;
		logic                  jump_request;
		logic                  return_request;
		logic                  send_request;
		logic [1:0]            ram_chip;
		logic [5:0]            ram_address;
		logic [3:0]            rom_chip;
		logic [BYTE_W-1:0]     fetch_address;
		logic [TICK_OUT_W-1:0] tick_count;
	} result_t;

endpackage

`default_nettype wire

[rtl/nce_regfile.sv]
// Register file of sixteen 4-bit registers, kept as eight pair rows.
// The even register of a pair is the high nibble. Depends on nce_pkg.
`default_nettype none

module nce_regfile (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [nce_pkg::ROW_W-1:0] rd_row,
	output logic [nce_pkg::BYTE_W-1:0]     rd_data,
	output logic [nce_pkg::BYTE_W-1:0]     pair0,
	input  wire nce_pkg::rf_wr_t           wr
);
	import nce_pkg::*;

	logic [BYTE_W-1:0] rows_q [ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			if (wr.en_hi) begin
				rows_q[wr.row][7:4] <= wr.data[7:4];
			end
			if (wr.en_lo) begin
				rows_q[wr.row][3:0] <= wr.data[3:0];
			end
		end
	end

	assign rd_data = rows_q[rd_row];
	assign pair0   = rows_q[0];

endmodule

`default_nettype wire

[rtl/nce_execute.sv]
// Execute logic: decodes one instruction and forms the next accumulator, carry,
// tick count, register write and result. Depends on nce_pkg.
`default_nettype none

module nce_execute #(
	parameter int TICK_WIDTH = nce_pkg::TICK_WIDTH_DEF
) (
	input  wire nce_pkg::instr_t           instr,
	input  wire logic [nce_pkg::BYTE_W-1:0] row_data,
	input  wire logic [nce_pkg::BYTE_W-1:0] pair0,
	input  wire logic [nce_pkg::NIB_W-1:0]  acc,
	input  wire logic                       carry,
	input  wire logic [TICK_WIDTH-1:0]      tick,
	output logic [nce_pkg::NIB_W-1:0]       acc_next,
	output logic                            carry_next,
	output logic [TICK_WIDTH-1:0]           tick_next,
	output nce_pkg::rf_wr_t                 wr,
	output nce_pkg::result_t                result
);
	import nce_pkg::*;

	logic [NIB_W-1:0]  opa;
	logic [NIB_W-1:0]  reg_val;
	logic [NIB_W:0]    sum_add;
	logic [NIB_W:0]    sum_sub;
	logic [BYTE_W-1:0] pair;
	logic              jump;
	logic              ret;
	logic              send;
	logic              is_fin;
	logic [TICK_OUT_W-1:0] tick_out;

	assign opa     = instr.operand_nibble;
	assign reg_val = opa[0] ? row_data[3:0] : row_data[7:4];
	assign sum_add = {1'b0, acc} + {1'b0, reg_val} + {{NIB_W{1'b0}}, carry};
	assign sum_sub = {1'b0, acc} + {1'b0, reg_val ^ NIB_ALL} + {{NIB_W{1'b0}}, !carry};
	assign is_fin  = (instr.opcode == OP_FIN);

	always_comb begin
		acc_next   = acc;
		carry_next = carry;
		pair       = '0;
		jump       = 1'b0;
		ret        = 1'b0;
		send       = 1'b0;
		wr.en_hi   = 1'b0;
		wr.en_lo   = 1'b0;
		wr.row     = opa[3:1];
		wr.data    = {acc, acc};
		unique case (instr.opcode)
			OP_NOP: begin
			end
			OP_LDM: begin
				acc_next = opa;
			end
			OP_LD: begin
				acc_next = reg_val;
			end
			OP_XCH: begin
				acc_next = reg_val;
				wr.en_hi = !opa[0];
				wr.en_lo = opa[0];
			end
			OP_ADD: begin
				acc_next   = sum_add[NIB_W-1:0];
				carry_next = sum_add[NIB_W];
			end
			OP_SUB: begin
				acc_next   = sum_sub[NIB_W-1:0];
				carry_next = !sum_sub[NIB_W];
			end
			OP_INC: begin
				wr.en_hi = !opa[0];
				wr.en_lo = opa[0];
				wr.data  = {reg_val + 4'd1, reg_val + 4'd1};
			end
			OP_BBL: begin
				acc_next = opa;
				ret      = 1'b1;
			end
			OP_JIN: begin
				pair = row_data;
				jump = 1'b1;
			end
			OP_SRC: begin
				pair = row_data;
				send = 1'b1;
			end
			OP_FIN: begin
				wr.en_hi = 1'b1;
				wr.en_lo = 1'b1;
				wr.data  = instr.rom_byte;
			end
			OP_CLB: begin
				acc_next   = '0;
				carry_next = 1'b0;
			end
			OP_CLC: begin
				carry_next = 1'b0;
			end
			OP_CMC: begin
				carry_next = !carry;
			end
			OP_STC: begin
				carry_next = 1'b1;
			end
			OP_CMA: begin
				acc_next = acc ^ NIB_ALL;
			end
			default: begin
			end
		endcase
	end

	assign tick_next = tick + (is_fin ? TICK_WIDTH'(2) : TICK_WIDTH'(1));

	generate
		if (TICK_WIDTH >= TICK_OUT_W) begin : g_tick_wide
			assign tick_out = tick_next[TICK_OUT_W-1:0];
		end else begin : g_tick_narrow
			assign tick_out = {{(TICK_OUT_W-TICK_WIDTH){1'b0}}, tick_next};
		end
	endgenerate

	always_comb begin
		result.acc_value      = acc_next;
		result.carry_value    = carry_next;
		result.pair_value     = pair;
		result.jump_request   = jump;
		result.return_request = ret;
		result.send_request   = send;
		result.ram_chip       = send ? pair[7:6] : 2'b00;
		result.ram_address    = send ? pair[5:0] : 6'b000000;
		result.rom_chip       = send ? pair[7:4] : 4'b0000;
		result.fetch_address  = pair0;
		result.tick_count     = tick_out;
	end

endmodule

`default_nettype wire

[rtl/nibble_cpu_register_alu_execute.sv]
// Top level of the nibble CPU register and accumulator execute block.
// Instantiates nce_regfile and nce_execute; depends on nce_pkg.
//
// The block executes one instruction per input transfer and gives exactly one
// result transfer for it. With the output side ready the block sustains one
// instruction per clock. An instruction waits in the input register while the
// execute step forms its result; when it advances (the result register is empty
// or its result is taken), the edge updates the register file, accumulator, carry
// and tick counter and loads the result register, which drives the output.
// While a finished result waits, the input register takes a transfer only if it
// is empty.
// Input tdata: opcode [3:0], operand_nibble [7:4], rom_byte [15:8].
`default_nettype none

module nibble_cpu_register_alu_execute #(
	parameter int TICK_WIDTH = nce_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// opcode, operand_nibble, rom_byte
	input  wire logic [nce_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// acc_value, carry_value, pair_value, jump_request, return_request,
	// send_request, ram_chip, ram_address, rom_chip, fetch_address, tick_count
	output logic [nce_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import nce_pkg::*;

	logic              valid_s1;
	instr_t            instr_s1;
	logic              valid_s2;
	result_t           result_s2;
	logic              advance;

	logic [NIB_W-1:0]      acc_q;
	logic                  carry_q;
	logic [TICK_WIDTH-1:0] tick_q;

	logic [BYTE_W-1:0]     row_data;
	logic [BYTE_W-1:0]     pair0;
	logic [NIB_W-1:0]      acc_next;
	logic                  carry_next;
	logic [TICK_WIDTH-1:0] tick_next;
	rf_wr_t                exe_wr;
	rf_wr_t                rf_wr;
	result_t               exe_result;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= instr_t'(s_tdata);
		end
	end

	nce_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_row  (instr_s1.operand_nibble[3:1]),
		.rd_data (row_data),
		.pair0   (pair0),
		.wr      (rf_wr)
	);

	nce_execute #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_execute (
		.instr      (instr_s1),
		.row_data   (row_data),
		.pair0      (pair0),
		.acc        (acc_q),
		.carry      (carry_q),
		.tick       (tick_q),
		.acc_next   (acc_next),
		.carry_next (carry_next),
		.tick_next  (tick_next),
		.wr         (exe_wr),
		.result     (exe_result)
	);

	always_comb begin
		rf_wr       = exe_wr;
		rf_wr.en_hi = exe_wr.en_hi && advance;
		rf_wr.en_lo = exe_wr.en_lo && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			carry_q  <= 1'b0;
			tick_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				acc_q    <= acc_next;
				carry_q  <= carry_next;
				tick_q   <= tick_next;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= exe_result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		4'b0000,
		result_s2.tick_count,
		result_s2.fetch_address,
		result_s2.rom_chip,
		result_s2.ram_address,
		result_s2.ram_chip,
		result_s2.send_request,
		result_s2.return_request,
		result_s2.jump_request,
		result_s2.pair_value,
		result_s2.carry_value,
		result_s2.acc_value
	};

endmodule

`default_nettype wire

[rtl/nce_checker.sv]
// Port-level checker for the nibble CPU execute block, with its bind statement.
// Watches the result channel only; depends on nibble_cpu_register_alu_execute.
`default_nettype none

module nce_port_checker #(
	parameter int TICK_WIDTH = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);

	// The tick field wraps at the counter width when that is below 32 bits.
	localparam logic [31:0] TICK_MASK = (TICK_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << TICK_WIDTH) - 64'd1);

	logic        have_last_q;
	logic [31:0] last_tick_q;
	logic [31:0] tick;
	logic [31:0] tick_delta;
	logic        jump;
	logic        ret;
	logic        send;
	logic [7:0]  pair;
	logic [1:0]  ram_chip;
	logic [5:0]  ram_address;
	logic [3:0]  rom_chip;

	assign pair        = m_tdata[12:5];
	assign jump        = m_tdata[13];
	assign ret         = m_tdata[14];
	assign send        = m_tdata[15];
	assign ram_chip    = m_tdata[17:16];
	assign ram_address = m_tdata[23:18];
	assign rom_chip    = m_tdata[27:24];
	assign tick        = m_tdata[67:36];
	assign tick_delta  = (tick - last_tick_q) & TICK_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q <= 1'b0;
			last_tick_q <= '0;
		end else if (m_tvalid && m_tready) begin
			have_last_q <= 1'b1;
			last_tick_q <= tick;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed or vanished while stalled.");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({jump, ret, send}) <= 1)
		else $error("More than one request in one result.");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && have_last_q |->
			(tick_delta == 32'd1) || (tick_delta == 32'd2))
		else $error("Tick count did not advance by one or two.");

	a_send_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && send |-> {ram_chip, ram_address} == pair && rom_chip == pair[7:4])
		else $error("Chip and address fields disagree with the pair.");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !send |-> ram_chip == 2'b00 && ram_address == 6'b000000
			&& rom_chip == 4'b0000 && (jump || pair == 8'h00))
		else $error("Pair or chip fields set without a request.");

endmodule

bind nibble_cpu_register_alu_execute nce_port_checker #(
	.TICK_WIDTH (TICK_WIDTH)
) u_nce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[verif/nce_checker.sv]
// Checker for the nibble CPU register and accumulator execute block.
// Watches both stream channels, predicts each result and compares it field by field.
// Depends on nce_pkg for the opcode codes and the stream widths.
`timescale 1ns / 100ps

module nce_checker #(
	parameter int TICK_W = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [nce_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [nce_pkg::OUT_DATA_W-1:0]    m_tdata,
	output int                                mismatches,
	output int                                outstanding
);
	import nce_pkg::*;

	typedef struct packed {
		logic [3:0]  acc;
		logic        carry;
		logic [7:0]  pair;
		logic        jump;
		logic        ret;
		logic        send;
		logic [1:0]  ram_chip;
		logic [5:0]  ram_addr;
		logic [3:0]  rom_chip;
		logic [7:0]  fetch;
		logic [31:0] ticks;
	} exec_result_t;

	logic [3:0]        regs [16];
	logic [3:0]        acc;
	logic              carry;
	logic [TICK_W-1:0] tick_cnt;
	exec_result_t      pending_q [$];
	int                fails = 0;

	function automatic logic [7:0] pair_of(input logic [2:0] p);
		return {regs[{p, 1'b0}], regs[{p, 1'b1}]};
	endfunction

	task automatic execute_instr(input logic [IN_DATA_W-1:0] d);
		logic [3:0]   op;
		logic [3:0]   opnd;
		logic [7:0]   rom;
		logic [2:0]   p;
		logic [4:0]   sum;
		logic [3:0]   tmp;
		exec_result_t r;
		op   = d[3:0];
		opnd = d[7:4];
		rom  = d[15:8];
		p    = opnd[3:1];
		r    = '0;
		r.fetch = pair_of(3'd0);
		tick_cnt = tick_cnt + TICK_W'(1);
		case (op)
			OP_LDM: acc = opnd;
			OP_LD:  acc = regs[opnd];
			OP_XCH: begin
				tmp = acc;
				acc = regs[opnd];
				regs[opnd] = tmp;
			end
			OP_ADD: begin
				sum   = {1'b0, acc} + {1'b0, regs[opnd]} + {4'd0, carry};
				carry = sum[4];
				acc   = sum[3:0];
			end
			OP_SUB: begin
				sum   = {1'b0, acc} + {1'b0, ~regs[opnd]} + {4'd0, ~carry};
				carry = ~sum[4];
				acc   = sum[3:0];
			end
			OP_INC: regs[opnd] = regs[opnd] + 4'd1;
			OP_BBL: begin
				acc   = opnd;
				r.ret = 1'b1;
			end
			OP_JIN: begin
				r.pair = pair_of(p);
				r.jump = 1'b1;
			end
			OP_SRC: begin
				r.pair     = pair_of(p);
				r.send     = 1'b1;
				r.ram_chip = r.pair[7:6];
				r.ram_addr = r.pair[5:0];
				r.rom_chip = r.pair[7:4];
			end
			OP_FIN: begin
				regs[{p, 1'b0}] = rom[7:4];
				regs[{p, 1'b1}] = rom[3:0];
				tick_cnt = tick_cnt + TICK_W'(1);
			end
			OP_CLB: begin
				acc   = 4'd0;
				carry = 1'b0;
			end
			OP_CLC: carry = 1'b0;
			OP_CMC: carry = ~carry;
			OP_STC: carry = 1'b1;
			OP_CMA: acc = ~acc;
			default: ;
		endcase
		r.acc   = acc;
		r.carry = carry;
		r.ticks = 32'(tick_cnt);
		pending_q.push_back(r);
	endtask

	task automatic cmp(input string name, input longint unsigned e, input longint unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
			fails++;
		end
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] d);
		exec_result_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: result transfer with none expected: actual %0h", $time, d);
			fails++;
		end else begin
			e = pending_q.pop_front();
			cmp("acc_value", e.acc, d[3:0]);
			cmp("carry_value", e.carry, d[4]);
			cmp("pair_value", e.pair, d[12:5]);
			cmp("jump_request", e.jump, d[13]);
			cmp("return_request", e.ret, d[14]);
			cmp("send_request", e.send, d[15]);
			cmp("ram_chip", e.ram_chip, d[17:16]);
			cmp("ram_address", e.ram_addr, d[23:18]);
			cmp("rom_chip", e.rom_chip, d[27:24]);
			cmp("fetch_address", e.fetch, d[35:28]);
			cmp("tick_count", e.ticks, d[67:36]);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				regs[i] = 4'd0;
			acc      = 4'd0;
			carry    = 1'b0;
			tick_cnt = '0;
			pending_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				execute_instr(s_tdata);
			if (m_tvalid && m_tready)
				check_result(m_tdata);
		end
		mismatches  <= fails;
		outstanding <= pending_q.size();
	end

endmodule

[verif/tb_top.sv]
// Top of the testbench for the nibble CPU register and accumulator execute block.
// Drives directed then random instructions with random gaps and stalls; verdict
// comes from nce_checker. Depends on nce_pkg and the block itself.
`timescale 1ns / 100ps

module tb_top;
	import nce_pkg::*;

	localparam int TICK_W    = TICK_WIDTH_DEF;
	localparam int N_RANDOM  = 1850;
	localparam int LIMIT     = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  quiet = 1'b0;
	int                    mismatches;
	int                    outstanding;
	int                    cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	nibble_cpu_register_alu_execute #(
		.TICK_WIDTH(TICK_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nce_checker #(
		.TICK_W(TICK_W)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 21);
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic issue(input logic [3:0] op, input logic [3:0] opnd, input logic [7:0] rom);
		while (!quiet && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rom, opnd, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_LDM, 4'd15, 8'h00);
		issue(OP_XCH, 4'd0, 8'h00);
		issue(OP_LDM, 4'd9, 8'h00);
		issue(OP_XCH, 4'd1, 8'h00);
		issue(OP_FIN, 4'd1, 8'hA5);
		issue(OP_JIN, 4'd1, 8'h00);
		issue(OP_SRC, 4'd0, 8'h00);
		issue(OP_FIN, 4'd15, 8'hFF);
		issue(OP_SRC, 4'd15, 8'h00);
		issue(OP_LD, 4'd15, 8'h00);
		issue(OP_STC, 4'd0, 8'h00);
		issue(OP_ADD, 4'd14, 8'h00);
		issue(OP_SUB, 4'd0, 8'h00);
		issue(OP_SUB, 4'd15, 8'h00);
		issue(OP_INC, 4'd15, 8'h00);
		issue(OP_CMC, 4'd0, 8'h00);
		issue(OP_CLC, 4'd0, 8'h00);
		issue(OP_CMA, 4'd0, 8'h00);
		issue(OP_BBL, 4'd7, 8'h00);
		issue(OP_CLB, 4'd0, 8'h00);
		issue(OP_NOP, 4'd15, 8'hFF);
		issue(OP_JIN, 4'd14, 8'h00);
		issue(OP_FIN, 4'd0, 8'h00);
		issue(OP_ADD, 4'd0, 8'h00);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 700)
				drain();
			if (i == 900)
				quiet <= 1'b1;
			if (i == 1250)
				quiet <= 1'b0;
			issue(4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom_range(255)));
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/nce_pkg.sv
rtl/nce_regfile.sv
rtl/nce_execute.sv
rtl/nibble_cpu_register_alu_execute.sv
rtl/nce_checker.sv
verif/nce_checker.sv
verif/tb_top.sv
